// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker module ept_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define EPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("extremum period tracker check failed");

// Checks an implication from an antecedent to a consequent.
`define EPT_ASSERT_IMP(lbl, ante, cons) \
  `EPT_ASSERT(lbl, (ante) |-> (cons))

// Checks an implication whose consequent holds in the cycle after the antecedent.
`define EPT_ASSERT_NEXT(lbl, ante, cons) \
  `EPT_ASSERT(lbl, (ante) |=> (cons))

`endif

// ===== rtl/ept_pkg.sv =====
package ept_pkg;

  localparam int unsigned CHANNELS_DEF    = 6;
  localparam int unsigned RING_DEPTH_DEF  = 128;
  localparam int unsigned SAMPLE_BITS_DEF = 32;
  localparam int unsigned THR_W           = 31;

  typedef struct packed {
    logic [2:0]         channel;
    logic signed [31:0] sample_value;
    logic [31:0]        sample_time;
    logic               step_last;
  } ept_in_t;

  typedef struct packed {
    logic [2:0]         channel_echo;
    logic               found_maximum;
    logic               found_minimum;
    logic signed [31:0] mean_maximum;
    logic signed [31:0] mean_minimum;
    logic [31:0]        mean_period;
    logic               converged;
  } ept_out_t;

  typedef enum logic [0:0] {
    KIND_MAX = 1'b0,
    KIND_MIN = 1'b1
  } kind_e;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_RD0  = 10'b0000000010,
    ST_RD1  = 10'b0000000100,
    ST_RD2  = 10'b0000001000,
    ST_RD3  = 10'b0000010000,
    ST_UPD0 = 10'b0000100000,
    ST_UPD1 = 10'b0001000000,
    ST_DIV  = 10'b0010000000,
    ST_WAIT = 10'b0100000000,
    ST_DONE = 10'b1000000000
  } state_e;

  function automatic logic [31:0] abs_gap(input logic [31:0] a, input logic [31:0] b);
    abs_gap = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== rtl/ept_ring_mem.sv =====
module ept_ring_mem #(
  parameter int unsigned AW = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wval_i,
  input  logic [31:0]   wtime_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rval_o,
  output logic [31:0]   rtime_o
);

  logic [31:0] val_mem  [2**AW];
  logic [31:0] time_mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      val_mem[waddr_i]  <= wval_i;
      time_mem[waddr_i] <= wtime_i;
    end
    rval_o  <= val_mem[raddr_i];
    rtime_o <= time_mem[raddr_i];
  end

endmodule

// ===== rtl/ept_divider.sv =====
module ept_divider #(
  parameter int unsigned NUM_W = 41,
  parameter int unsigned DEN_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  always_comb begin
    trial  = {rem_q, quo_q[NUM_W-1]};
    fits   = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], fits};
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/extremum_period_tracker_unit.sv =====
// Channel  | Handshake                | Payload
// ---------+--------------------------+-----------------------
// input    | in_valid_i / in_stall_o  | in_data_i (ept_in_t)
// output   | out_valid_o / out_stall_i| out_data_o (ept_out_t)
// config   | cfg_we_i                 | cfg_data_i (threshold)
// One transaction is processed at a time; a sample with no extremum goes through ST_DIV and ST_WAIT
// and waits for the bit-serial dividers, TOT_W = 33 + clog2(RING_DEPTH + 1) bits long (41 at
// the default depth); a stored extremum first adds the ring memory reads and writes of RD0 to UPD1.
// A sample for an unknown channel goes straight to ST_DONE and skips the dividers.
// Reset clears all channel state; the ring memory needs no clearing because the fill counts
// guard every read. A stalled result holds the block in its final state until it is taken.
module extremum_period_tracker_unit #(
  parameter int unsigned CHANNELS    = ept_pkg::CHANNELS_DEF,
  parameter int unsigned RING_DEPTH  = ept_pkg::RING_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = ept_pkg::SAMPLE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  ept_pkg::ept_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output ept_pkg::ept_out_t         out_data_o,
  input  logic                      cfg_we_i,
  input  logic [ept_pkg::THR_W-1:0] cfg_data_i
);

  localparam int unsigned SW     = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SLOT_W = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned TOT_W  = 33 + FILL_W;
  localparam int unsigned DEN_W  = FILL_W + 1;
  localparam int unsigned AW     = 1 + CH_W + SLOT_W;

  ept_pkg::state_e state_q, state_d;

  ept_pkg::ept_in_t   item_q;
  logic [CH_W-1:0]    cidx_q;
  logic               chv_q, fmax_q, fmin_q, conv_q;
  ept_pkg::kind_e     kind_q;
  logic signed [SW-1:0] p_q;
  logic [SLOT_W-1:0]  s_q;
  logic               full_q, nonempty_q;
  logic [31:0]        old_val_q, t_s_q, t_nxt_q, t_new_q;

  logic signed [SW-1:0] last_q  [CHANNELS];
  logic signed [SW-1:0] older_q [CHANNELS];
  logic [SLOT_W-1:0]    slot_q  [2][CHANNELS];
  logic [FILL_W-1:0]    fill_q  [2][CHANNELS];
  logic signed [TOT_W-1:0] vtot_q [2][CHANNELS];
  logic [TOT_W-1:0]     gap_q   [CHANNELS];
  logic                 stepc_q;
  logic [ept_pkg::THR_W-1:0] thr_q;

  logic                 out_valid_q;
  ept_pkg::ept_out_t    out_q;

  logic                 zx_q, zn_q, zg_q, negx_q, negn_q;

  logic                 acc;
  logic                 chv;
  logic [CH_W-1:0]      cidx;
  logic signed [SW-1:0] y, p, o;
  logic signed [SW:0]   d;
  logic [SW:0]          mag;
  logic                 ismax, ismin, moved, newflag;

  logic [SLOT_W-1:0]    nxt, newest;
  logic [AW-1:0]        raddr, waddr;
  logic [31:0]          rval, rtime;
  logic                 mem_we;

  logic [FILL_W-1:0]    fx, fn;
  logic [DEN_W-1:0]     ngaps;
  logic                 div_start;
  logic [TOT_W-1:0]     num_x, num_n;
  logic [TOT_W-1:0]     q_x, q_n, q_g;
  logic                 busy_x, busy_n, busy_g;
  logic                 out_load;
  logic [31:0]          mean_x, mean_n, mean_g;

  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ept_pkg::ST_IDLE);

  always_comb begin
    chv   = (32'(in_data_i.channel) < CHANNELS);
    cidx  = CH_W'(in_data_i.channel);
    y     = $signed(in_data_i.sample_value[SW-1:0]);
    p     = chv ? last_q[cidx] : '0;
    o     = chv ? older_q[cidx] : '0;
    ismax = (p > y) && (p > o);
    ismin = !ismax && (p < y) && (p < o);
    d     = (SW+1)'(y) - (SW+1)'(p);
    mag   = d[SW] ? $unsigned(-d) : $unsigned(d);
    moved = chv && (34'(mag) > 34'(thr_q));
    newflag = stepc_q && !moved;
  end

  assign nxt    = (s_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : s_q + 1'b1;
  assign newest = (s_q == '0) ? SLOT_W'(RING_DEPTH - 1) : s_q - 1'b1;

  always_comb begin
    unique case (state_q)
      ept_pkg::ST_RD2: raddr = {kind_q, cidx_q, nxt};
      ept_pkg::ST_RD3: raddr = {kind_q, cidx_q, newest};
      default:         raddr = {kind_q, cidx_q, s_q};
    endcase
  end

  assign waddr  = {kind_q, cidx_q, s_q};
  assign mem_we = (state_q == ept_pkg::ST_UPD0);

  ept_ring_mem #(
    .AW(AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wval_i  (32'(p_q)),
    .wtime_i (item_q.sample_time),
    .raddr_i (raddr),
    .rval_o  (rval),
    .rtime_o (rtime)
  );

  always_comb begin
    fx    = fill_q[ept_pkg::KIND_MAX][cidx_q];
    fn    = fill_q[ept_pkg::KIND_MIN][cidx_q];
    ngaps = ((fx != '0) ? DEN_W'(fx - 1'b1) : '0) + ((fn != '0) ? DEN_W'(fn - 1'b1) : '0);
    num_x = vtot_q[ept_pkg::KIND_MAX][cidx_q][TOT_W-1]
          ? $unsigned(-vtot_q[ept_pkg::KIND_MAX][cidx_q])
          : $unsigned(vtot_q[ept_pkg::KIND_MAX][cidx_q]);
    num_n = vtot_q[ept_pkg::KIND_MIN][cidx_q][TOT_W-1]
          ? $unsigned(-vtot_q[ept_pkg::KIND_MIN][cidx_q])
          : $unsigned(vtot_q[ept_pkg::KIND_MIN][cidx_q]);
  end

  assign div_start = (state_q == ept_pkg::ST_DIV);

  ept_divider #(.NUM_W(TOT_W), .DEN_W(DEN_W)) u_div_max (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_x), .den_i(DEN_W'(fx)),
    .busy_o(busy_x), .quo_o(q_x)
  );

  ept_divider #(.NUM_W(TOT_W), .DEN_W(DEN_W)) u_div_min (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_n), .den_i(DEN_W'(fn)),
    .busy_o(busy_n), .quo_o(q_n)
  );

  ept_divider #(.NUM_W(TOT_W), .DEN_W(DEN_W)) u_div_gap (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(gap_q[cidx_q]), .den_i(ngaps),
    .busy_o(busy_g), .quo_o(q_g)
  );

  assign out_load = (state_q == ept_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    mean_x = zx_q ? '0 : (negx_q ? 32'(-q_x) : q_x[31:0]);
    mean_n = zn_q ? '0 : (negn_q ? 32'(-q_n) : q_n[31:0]);
    mean_g = zg_q ? '0 : q_g[31:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ept_pkg::ST_IDLE: begin
        if (acc) begin
          if (!chv) begin
            state_d = ept_pkg::ST_DONE;
          end else if (ismax || ismin) begin
            state_d = ept_pkg::ST_RD0;
          end else begin
            state_d = ept_pkg::ST_DIV;
          end
        end
      end
      ept_pkg::ST_RD0:  state_d = ept_pkg::ST_RD1;
      ept_pkg::ST_RD1:  state_d = ept_pkg::ST_RD2;
      ept_pkg::ST_RD2:  state_d = ept_pkg::ST_RD3;
      ept_pkg::ST_RD3:  state_d = ept_pkg::ST_UPD0;
      ept_pkg::ST_UPD0: state_d = ept_pkg::ST_UPD1;
      ept_pkg::ST_UPD1: state_d = ept_pkg::ST_DIV;
      ept_pkg::ST_DIV:  state_d = ept_pkg::ST_WAIT;
      ept_pkg::ST_WAIT: begin
        if (!busy_x && !busy_n && !busy_g) begin
          state_d = ept_pkg::ST_DONE;
        end
      end
      ept_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = ept_pkg::ST_IDLE;
        end
      end
      default: state_d = ept_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ept_pkg::ST_IDLE;
      stepc_q     <= 1'b1;
      thr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        last_q[c]  <= '0;
        older_q[c] <= '0;
        gap_q[c]   <= '0;
        for (int k = 0; k < 2; k++) begin
          slot_q[k][c] <= '0;
          fill_q[k][c] <= '0;
          vtot_q[k][c] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (acc) begin
        stepc_q <= in_data_i.step_last ? 1'b1 : newflag;
        if (chv) begin
          older_q[cidx] <= last_q[cidx];
          last_q[cidx]  <= y;
        end
      end
      if (state_q == ept_pkg::ST_UPD0) begin
        vtot_q[kind_q][cidx_q] <= vtot_q[kind_q][cidx_q] + TOT_W'(p_q)
                                - (full_q ? TOT_W'($signed(old_val_q)) : '0);
        gap_q[cidx_q] <= gap_q[cidx_q]
                       - (full_q ? TOT_W'(ept_pkg::abs_gap(t_nxt_q, t_s_q)) : '0);
      end
      if (state_q == ept_pkg::ST_UPD1) begin
        gap_q[cidx_q] <= gap_q[cidx_q]
                       + (nonempty_q ? TOT_W'(ept_pkg::abs_gap(item_q.sample_time, t_new_q))
                                     : '0);
        slot_q[kind_q][cidx_q] <= nxt;
        if (!full_q) begin
          fill_q[kind_q][cidx_q] <= fill_q[kind_q][cidx_q] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      item_q <= in_data_i;
      cidx_q <= cidx;
      chv_q  <= chv;
      fmax_q <= chv && ismax;
      fmin_q <= chv && ismin;
      conv_q <= in_data_i.step_last && newflag;
      kind_q <= ismax ? ept_pkg::KIND_MAX : ept_pkg::KIND_MIN;
      p_q    <= p;
    end
    if (state_q == ept_pkg::ST_RD0) begin
      s_q        <= slot_q[kind_q][cidx_q];
      full_q     <= (fill_q[kind_q][cidx_q] == FILL_W'(RING_DEPTH));
      nonempty_q <= (fill_q[kind_q][cidx_q] != '0);
    end
    if (state_q == ept_pkg::ST_RD2) begin
      old_val_q <= rval;
      t_s_q     <= rtime;
    end
    if (state_q == ept_pkg::ST_RD3) begin
      t_nxt_q <= rtime;
    end
    if (state_q == ept_pkg::ST_UPD0) begin
      t_new_q <= rtime;
    end
    if (state_q == ept_pkg::ST_DIV) begin
      zx_q   <= (fx == '0);
      zn_q   <= (fn == '0);
      zg_q   <= (ngaps == '0);
      negx_q <= vtot_q[ept_pkg::KIND_MAX][cidx_q][TOT_W-1];
      negn_q <= vtot_q[ept_pkg::KIND_MIN][cidx_q][TOT_W-1];
    end
    if (out_load) begin
      out_q.channel_echo  <= chv_q ? item_q.channel : '0;
      out_q.found_maximum <= fmax_q;
      out_q.found_minimum <= fmin_q;
      out_q.mean_maximum  <= chv_q ? mean_x : '0;
      out_q.mean_minimum  <= chv_q ? mean_n : '0;
      out_q.mean_period   <= chv_q ? mean_g : '0;
      out_q.converged     <= conv_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/ept_checker.sv =====
`include "assert_macros.svh"

module ept_checker #(
  parameter int unsigned CHANNELS = ept_pkg::CHANNELS_DEF
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input ept_pkg::ept_in_t          in_data_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input ept_pkg::ept_out_t         out_data_o,
  input logic                      cfg_we_i,
  input logic [ept_pkg::THR_W-1:0] cfg_data_i
);

  logic in_acc;
  logic unused_ok;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign unused_ok = ^{in_data_i, cfg_we_i, cfg_data_i};

  `EPT_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall_o)
  `EPT_ASSERT_IMP(a_one_kind, out_valid_o, !(out_data_o.found_maximum && out_data_o.found_minimum))
  `EPT_ASSERT_IMP(a_echo_range, out_valid_o, 32'(out_data_o.channel_echo) < CHANNELS)
  `EPT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

endmodule

bind extremum_period_tracker_unit ept_checker #(.CHANNELS(CHANNELS)) u_ept_checker (.*);

// ===== tb/ept_checker.sv =====
module ept_scoreboard (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_o,
  input  ept_pkg::ept_in_t           in_data_i,
  input  logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  ept_pkg::ept_out_t          out_data_o,
  input  logic                       cfg_we_i,
  input  logic [30:0]                cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = ept_pkg::CHANNELS_DEF;
  localparam int DEPTH = ept_pkg::RING_DEPTH_DEF;

  logic [30:0] threshold;
  logic signed [63:0] prev_s [NCH];
  logic signed [63:0] older_s [NCH];
  logic signed [63:0] ext_val [2][NCH][DEPTH];
  logic [31:0] ext_when [2][NCH][DEPTH];
  int unsigned ext_slot [2][NCH];
  int unsigned ext_fill [2][NCH];
  logic signed [63:0] ext_sum [2][NCH];
  logic [63:0] gap_sum [NCH];
  logic step_ok;
  ept_pkg::ept_out_t expected_q [$];
  int mismatches;

  function automatic logic [63:0] time_gap(logic [31:0] a, logic [31:0] b);
    return (a > b) ? 64'(a - b) : 64'(b - a);
  endfunction

  task automatic store_extremum(ept_pkg::kind_e k, int ch, logic signed [63:0] v,
                                logic [31:0] t);
    int unsigned s;
    int unsigned nxt;
    int unsigned newest;
    s = ext_slot[k][ch];
    nxt = (s + 1) % DEPTH;
    newest = (s + DEPTH - 1) % DEPTH;
    if (ext_fill[k][ch] >= DEPTH) begin
      ext_sum[k][ch] -= ext_val[k][ch][s];
      gap_sum[ch] -= time_gap(ext_when[k][ch][nxt], ext_when[k][ch][s]);
    end
    if (ext_fill[k][ch] > 0) gap_sum[ch] += time_gap(t, ext_when[k][ch][newest]);
    ext_val[k][ch][s] = v;
    ext_when[k][ch][s] = t;
    ext_sum[k][ch] += v;
    ext_slot[k][ch] = nxt;
    if (ext_fill[k][ch] < DEPTH) ext_fill[k][ch]++;
  endtask

  function automatic logic signed [63:0] mean_of(ept_pkg::kind_e k, int ch);
    if (ext_fill[k][ch] == 0) return 0;
    return ext_sum[k][ch] / $signed(64'(ext_fill[k][ch]));
  endfunction

  task automatic predict_tracker(ept_pkg::ept_in_t it);
    ept_pkg::ept_out_t r;
    int ch;
    logic signed [63:0] y, p, o, d;
    logic [63:0] ngaps;
    r = '0;
    ch = int'(it.channel);
    if (ch < NCH) begin
      y = 64'(it.sample_value);
      p = prev_s[ch];
      o = older_s[ch];
      if (p > y && p > o) begin
        store_extremum(ept_pkg::KIND_MAX, ch, p, it.sample_time);
        r.found_maximum = 1'b1;
      end else if (p < y && p < o) begin
        store_extremum(ept_pkg::KIND_MIN, ch, p, it.sample_time);
        r.found_minimum = 1'b1;
      end
      d = y - p;
      if (d < 0) d = -d;
      if (d > $signed(64'(threshold))) step_ok = 1'b0;
      older_s[ch] = p;
      prev_s[ch] = y;
      r.channel_echo = it.channel;
      r.mean_maximum = 32'(mean_of(ept_pkg::KIND_MAX, ch));
      r.mean_minimum = 32'(mean_of(ept_pkg::KIND_MIN, ch));
      ngaps = 64'((ext_fill[ept_pkg::KIND_MAX][ch] ? ext_fill[ept_pkg::KIND_MAX][ch] - 1 : 0)
            + (ext_fill[ept_pkg::KIND_MIN][ch] ? ext_fill[ept_pkg::KIND_MIN][ch] - 1 : 0));
      if (ngaps != 0) r.mean_period = 32'(gap_sum[ch] / ngaps);
    end
    if (it.step_last) begin
      r.converged = step_ok;
      step_ok = 1'b1;
    end
    expected_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ept_pkg::ept_out_t e;
    if (!rst_ni) begin
      threshold = '0;
      for (int c = 0; c < NCH; c++) begin
        prev_s[c] = 0;
        older_s[c] = 0;
        gap_sum[c] = 0;
        for (int k = 0; k < 2; k++) begin
          ext_slot[k][c] = 0;
          ext_fill[k][c] = 0;
          ext_sum[k][c] = 0;
        end
      end
      step_ok = 1'b1;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) threshold = cfg_data_i;
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%t unexpected result %p", $realtime, out_data_o);
        end else begin
          e = expected_q.pop_front();
          if (e !== out_data_o) begin
            mismatches++;
            if (mismatches <= 10) $display("%t mismatch exp %p act %p", $realtime, e, out_data_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) predict_tracker(in_data_i);
    end
  end

  assign fail_count_o = mismatches;
  assign pending_o = expected_q.size();
endmodule

// ===== tb/tb_extremum_period_tracker_unit.sv =====
module tb_extremum_period_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ept_pkg::ept_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  ept_pkg::ept_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [ept_pkg::THR_W-1:0] cfg_data_i = '0;
  int fail_count;
  int pending;
  int stall_mode = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  extremum_period_tracker_unit dut (.*);

  ept_scoreboard checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i,
    .out_data_o, .cfg_we_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) begin
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 1) == 0);
    endcase
  end

  task automatic send_sample(logic [2:0] ch, logic signed [31:0] v, logic [31:0] t,
                             logic last);
    in_data_i <= '{channel: ch, sample_value: v, sample_time: t, step_last: last};
    in_valid_i <= 1'b1;
    while (in_stall_o) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 30)) @(negedge clk_i);
  endtask

  task automatic write_threshold(logic [30:0] v);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    cfg_data_i <= v;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_value(int shape);
    case (shape)
      0: return $urandom();
      1: return $signed(32'($urandom_range(0, 40))) - 20;
      default: return $signed($urandom()) >>> $urandom_range(0, 24);
    endcase
  endfunction

  initial begin
    logic [31:0] t;
    int burst;
    int shape;
    int stepn;
    t = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_sample(0, 32'sh7fffffff, 0, 0);
    send_sample(0, 32'sh80000000, 32'hffffffff, 0);
    send_sample(0, 32'sh7fffffff, 10, 0);
    send_sample(0, 32'sh7fffffff, 20, 0);
    send_sample(0, 0, 5, 1);
    send_sample(1, 5, 30, 0);
    send_sample(1, 5, 40, 0);
    send_sample(1, -5, 50, 0);
    send_sample(1, 7, 60, 1);
    send_sample(6, 123, 70, 1);
    send_sample(7, -1, 80, 0);
    send_sample(5, 1, 90, 1);
    send_sample(2, 0, 95, 1);
    write_threshold(31'h7fffffff);
    send_sample(3, 32'sh80000000, 100, 1);
    send_sample(3, 32'sh7fffffff, 110, 1);
    write_threshold(31'h0);
    send_sample(4, 0, 120, 1);
    send_sample(4, 1, 130, 1);
    for (int i = 0; i < 1450; i++) begin
      if (i % 300 == 150) begin
        write_threshold((i % 600 == 150) ? 31'($urandom_range(0, 4096)) : 31'($urandom()));
        stall_mode = $urandom_range(0, 2);
      end
      shape = (i / 100) % 3;
      if ($urandom_range(0, 3) == 0) idle_gap();
      stepn = $urandom_range(0, 5);
      t = ($urandom_range(0, 19) == 0) ? $urandom() : t + $urandom_range(0, 600);
      send_sample(($urandom_range(0, 24) == 0) ? 3'($urandom_range(6, 7)) :
                  3'($urandom_range(0, 5)), rand_value(shape), t, stepn == 0);
    end
    in_valid_i <= 1'b0;
    fork
      while (pending != 0) @(negedge clk_i);
    join
    repeat (100) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== extremum_period_tracker_unit.f =====
+incdir+rtl
rtl/ept_pkg.sv
rtl/ept_ring_mem.sv
rtl/ept_divider.sv
rtl/extremum_period_tracker_unit.sv
rtl/ept_checker.sv
tb/ept_checker.sv
tb/tb_extremum_period_tracker_unit.sv
